// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checker file of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is low.
`define FCTS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define FCTS_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/fcts_pkg.sv =====
// Shared constants, types and the CORDIC arctangent table of the FOC transform.
// No dependencies.
`default_nettype none

package fcts_pkg;

    // Register indexes of the configuration port
    localparam logic [2:0] REG_PWM_PERIOD = 3'd0;
    localparam logic [2:0] REG_OFFSET_A   = 3'd1;
    localparam logic [2:0] REG_OFFSET_B   = 3'd2;
    localparam logic [2:0] REG_GAIN_A     = 3'd3;
    localparam logic [2:0] REG_GAIN_B     = 3'd4;
    localparam logic [2:0] REG_DUTY_LIMIT = 3'd5;

    // Register reset values
    localparam logic [15:0] RST_PWM_PERIOD = 16'd56832;
    localparam logic [15:0] RST_OFFSET_A   = 16'd33322;
    localparam logic [15:0] RST_OFFSET_B   = 16'd32958;
    localparam logic [15:0] RST_GAIN_A     = 16'd358;
    localparam logic [15:0] RST_GAIN_B     = 16'd333;
    localparam logic [14:0] RST_DUTY_LIMIT = 15'd15565;

    // Fixed-point constants
    localparam int CORDIC_STEPS        = 28;
    localparam int SQRT3_HALF_Q16      = 56756;
    localparam int INV_SQRT3_Q16       = 37837;
    localparam int TWO_INV_SQRT3_Q16   = 75674;
    localparam int CORDIC_INV_GAIN_Q16 = 39797;
    localparam int HALF_DUTY           = 16384;
    localparam int ZW                  = 33;     // CORDIC angle width

    // Results of the voltage path, carried alongside the current path
    typedef struct packed {
        logic signed [15:0] pa;
        logic [2:0][14:0]   duty;
        logic [2:0][15:0]   cset;
        logic [2:0][15:0]   cclr;
    } t_side;

    // atan(2^-i) in units of 2^32 per turn
    function automatic logic [29:0] f_atan(input int i);
        logic [29:0] v;
        case (i)
            0:  v = 30'd536870912;
            1:  v = 30'd316933406;
            2:  v = 30'd167458907;
            3:  v = 30'd85004756;
            4:  v = 30'd42667331;
            5:  v = 30'd21354465;
            6:  v = 30'd10679838;
            7:  v = 30'd5340245;
            8:  v = 30'd2670163;
            9:  v = 30'd1335087;
            10: v = 30'd667544;
            11: v = 30'd333772;
            12: v = 30'd166886;
            13: v = 30'd83443;
            14: v = 30'd41722;
            15: v = 30'd20861;
            16: v = 30'd10430;
            17: v = 30'd5215;
            18: v = 30'd2608;
            19: v = 30'd1304;
            20: v = 30'd652;
            21: v = 30'd326;
            22: v = 30'd163;
            23: v = 30'd81;
            24: v = 30'd41;
            25: v = 30'd20;
            26: v = 30'd10;
            27: v = 30'd5;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fcts_if.sv =====
// Valid/ready channel interfaces: input samples, results and register writes.
// No dependencies.
`default_nettype none

interface fcts_in_if #(parameter int ADC_BITS = 12, parameter int ANGLE_BITS = 16);
    logic                  valid;
    logic                  ready;
    logic [ADC_BITS-1:0]   adc_a;
    logic [ADC_BITS-1:0]   adc_b;
    logic [ANGLE_BITS-1:0] rotor_angle;
    logic signed [15:0]    v_alpha;
    logic signed [15:0]    v_beta;
    modport source (output valid, adc_a, adc_b, rotor_angle, v_alpha, v_beta, input ready);
    modport sink   (input valid, adc_a, adc_b, rotor_angle, v_alpha, v_beta, output ready);
endinterface

interface fcts_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] phase_a_current;
    logic signed [15:0] id_current;
    logic signed [15:0] iq_current;
    logic [14:0]        duty_a;
    logic [14:0]        duty_b;
    logic [14:0]        duty_c;
    logic [15:0]        cmp_a_set;
    logic [15:0]        cmp_a_clear;
    logic [15:0]        cmp_b_set;
    logic [15:0]        cmp_b_clear;
    logic [15:0]        cmp_c_set;
    logic [15:0]        cmp_c_clear;
    modport source (output valid, phase_a_current, id_current, iq_current, duty_a, duty_b,
                    duty_c, cmp_a_set, cmp_a_clear, cmp_b_set, cmp_b_clear, cmp_c_set,
                    cmp_c_clear, input ready);
    modport sink   (input valid, phase_a_current, id_current, iq_current, duty_a, duty_b,
                    duty_c, cmp_a_set, cmp_a_clear, cmp_b_set, cmp_b_clear, cmp_c_set,
                    cmp_c_clear, output ready);
endinterface

interface fcts_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/fcts_cordic.sv =====
// Pipelined rotation-mode CORDIC, one micro-rotation per register stage.
// Depends on fcts_pkg (step count, arctangent table).
`default_nettype none

module fcts_cordic
    import fcts_pkg::*;
#(
    parameter int CW = 42
) (
    input  wire logic                    i_clk,
    input  wire logic [CORDIC_STEPS-1:0] i_en,
    input  wire logic signed [CW-1:0]    i_x,
    input  wire logic signed [CW-1:0]    i_y,
    input  wire logic signed [ZW-1:0]    i_z,
    output logic signed [CW-1:0]         o_x,
    output logic signed [CW-1:0]         o_y
);

    logic signed [CW-1:0] r_x [CORDIC_STEPS];
    logic signed [CW-1:0] r_y [CORDIC_STEPS];
    logic signed [ZW-1:0] r_z [CORDIC_STEPS];

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic signed [ZW-1:0] pz;
        logic signed [ZW-1:0] atan_s;

        if (g == 0) begin : g_first
            assign px = i_x;
            assign py = i_y;
            assign pz = i_z;
        end else begin : g_next
            assign px = r_x[g-1];
            assign py = r_y[g-1];
            assign pz = r_z[g-1];
        end

        assign atan_s = $signed(ZW'(f_atan(g)));

        // rotate toward zero residual angle
        always_ff @(posedge i_clk) begin
            if (i_en[g]) begin
                if (pz >= 0) begin
                    r_x[g] <= px - (py >>> g);
                    r_y[g] <= py + (px >>> g);
                    r_z[g] <= pz - atan_s;
                end else begin
                    r_x[g] <= px + (py >>> g);
                    r_y[g] <= py - (px >>> g);
                    r_z[g] <= pz + atan_s;
                end
            end
        end
    end

    assign o_x = r_x[CORDIC_STEPS-1];
    assign o_y = r_y[CORDIC_STEPS-1];

endmodule

`default_nettype wire

// ===== rtl/core/foc_current_transform_svpwm_top.sv =====
// FOC current transform (scale, Clarke, Park) and three-sector SVPWM duty/compare unit.
// Depends on fcts_pkg, fcts_if and fcts_cordic.
//
// One beat in gives one beat out; a new beat is taken every cycle unless a stall has
// reached the input. The pipeline is the 28-stage CORDIC of the Park rotation, four
// front stages for offset/gain scaling and the Clarke terms, and three stages that
// remove the CORDIC gain. Each stage advances when it is empty or the stage after it
// moves, so a stalled output holds its beat while the stages behind it keep filling
// up. The register port is always ready; write it only while no beat is in flight.
`default_nettype none

module foc_current_transform_svpwm_top
    import fcts_pkg::*;
#(
    parameter int ADC_BITS   = 12,
    parameter int ANGLE_BITS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fcts_in_if.sink   i_in,
    fcts_out_if.source o_out,
    fcts_cfg_if.sink  i_cfg
);

    // datapath widths
    localparam int DW  = (ADC_BITS + 5 > 17) ? ADC_BITS + 5 : 17; // offset-corrected sample
    localparam int PW  = DW + 17;                                 // sample times gain
    localparam int IW  = DW + 5;                                  // current in mA
    localparam int AW  = IW + 2;                                  // alpha term
    localparam int CW  = IW + 20;                                 // CORDIC x/y, Q.16
    localparam int HW  = CW + 1;                                  // high partial product
    localparam int SW  = CW + 18;                                 // gain sum
    localparam int RW  = CW - 14;                                 // rounded Id/Iq
    localparam int DDW = 20;                                      // raw sector duty

    localparam int S_CORD = 4;
    localparam int S_G1   = S_CORD + CORDIC_STEPS;
    localparam int NSTG   = S_G1 + 3;

    // configuration registers
    logic [15:0] r_period, r_off_a, r_off_b, r_gain_a, r_gain_b;
    logic [14:0] r_limit;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= RST_PWM_PERIOD;
            r_off_a  <= RST_OFFSET_A;
            r_off_b  <= RST_OFFSET_B;
            r_gain_a <= RST_GAIN_A;
            r_gain_b <= RST_GAIN_B;
            r_limit  <= RST_DUTY_LIMIT;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_PWM_PERIOD: r_period <= i_cfg.data;
                REG_OFFSET_A:   r_off_a  <= i_cfg.data;
                REG_OFFSET_B:   r_off_b  <= i_cfg.data;
                REG_GAIN_A:     r_gain_a <= i_cfg.data;
                REG_GAIN_B:     r_gain_b <= i_cfg.data;
                REG_DUTY_LIMIT: r_limit  <= i_cfg.data[14:0];
                default: ;
            endcase
        end
    end

    // stage valids and bubble-collapsing enables
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] en;

    assign en[NSTG-1] = !r_vld[NSTG-1] || o_out.ready;
    for (genvar s = 0; s < NSTG - 1; s++) begin : g_en
        assign en[s] = !r_vld[s] || en[s+1];
    end
    assign i_in.ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int s = 0; s < NSTG; s++) begin
                if (en[s]) begin
                    r_vld[s] <= (s == 0) ? i_in.valid : r_vld[(s == 0) ? 0 : s - 1];
                end
            end
        end
    end

    // ---------------- stage 0: offset/gain products, sector products, angle
    logic signed [DW-1:0]  diff_a, diff_b;
    logic [31:0]           ang_ext, ang_r;
    logic [2:0]            ang_q4;
    logic signed [PW-1:0]  r_pa0, r_pb0;
    logic signed [32:0]    r_tm0;
    logic signed [33:0]    r_um0;
    logic signed [15:0]    r_va0;
    logic [1:0]            r_q0;
    logic signed [ZW-1:0]  r_z0;

    assign diff_a  = $signed(DW'({i_in.adc_a, 4'b0000})) - $signed(DW'(r_off_a));
    assign diff_b  = $signed(DW'({i_in.adc_b, 4'b0000})) - $signed(DW'(r_off_b));
    assign ang_ext = {i_in.rotor_angle, {(32 - ANGLE_BITS){1'b0}}};
    assign ang_r   = 32'd0 - ang_ext;
    assign ang_q4  = 3'((33'(ang_r) + 33'h040000000) >> 30);

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_pa0 <= PW'(diff_a) * $signed({1'b0, r_gain_a});
            r_pb0 <= PW'(diff_b) * $signed({1'b0, r_gain_b});
            r_tm0 <= 33'(i_in.v_beta) * 33'(INV_SQRT3_Q16);
            r_um0 <= 34'(i_in.v_beta) * 34'(TWO_INV_SQRT3_Q16);
            r_va0 <= i_in.v_alpha;
            r_q0  <= ang_q4[1:0];
            r_z0  <= $signed(ZW'(ang_r)) - $signed(ZW'({ang_q4, 30'd0}));
        end
    end

    // ---------------- stage 1: round currents, pick sector
    logic signed [IW-1:0]  ia_c, ib_c;
    logic signed [17:0]    t_c;
    logic signed [18:0]    u_c;
    logic signed [DDW-1:0] va_e, t_e, a1, b1, b2, c2, a3, c3;
    logic signed [IW-1:0]  r_ia1, r_ib1;
    logic signed [15:0]    r_pa1;
    logic signed [DDW-1:0] r_d1 [3];
    logic [1:0]            r_q1;
    logic signed [ZW-1:0]  r_z1;

    assign ia_c = IW'((r_pa0 + PW'(2048)) >>> 12);
    assign ib_c = IW'((r_pb0 + PW'(2048)) >>> 12);
    assign t_c  = 18'((34'(r_tm0) + 34'(32768)) >>> 16);
    assign u_c  = 19'((35'(r_um0) + 35'(32768)) >>> 16);
    assign va_e = DDW'(r_va0);
    assign t_e  = DDW'(t_c);
    assign a1   = va_e + t_e;
    assign b1   = DDW'(u_c);
    assign b2   = t_e - va_e;
    assign c2   = -t_e - va_e;
    assign a3   = va_e - t_e;
    assign c3   = -DDW'(u_c);

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_ia1 <= ia_c;
            r_ib1 <= ib_c;
            if (ia_c > IW'(32767)) begin
                r_pa1 <= 16'sh7fff;
            end else if (ia_c < IW'(-32768)) begin
                r_pa1 <= -16'sh8000;
            end else begin
                r_pa1 <= ia_c[15:0];
            end
            if (a1 >= 0 && b1 >= 0) begin
                r_d1[0] <= a1;
                r_d1[1] <= b1;
                r_d1[2] <= '0;
            end else if (b2 >= 0 && c2 >= 0) begin
                r_d1[0] <= '0;
                r_d1[1] <= b2;
                r_d1[2] <= c2;
            end else begin
                r_d1[0] <= a3;
                r_d1[1] <= '0;
                r_d1[2] <= c3;
            end
            r_q1 <= r_q0;
            r_z1 <= r_z0;
        end
    end

    // ---------------- stage 2: Clarke terms, duty clamp
    logic signed [AW-1:0]    alpha_c;
    logic signed [IW+17:0]   beta_c;
    logic signed [CW-1:0]    r_x2, r_y2;
    logic signed [15:0]      r_pa2;
    logic [14:0]             r_dc2 [3];
    logic [1:0]              r_q2;
    logic signed [ZW-1:0]    r_z2;

    assign alpha_c = AW'(r_ia1) - (AW'(r_ib1) <<< 1);
    assign beta_c  = (IW+18)'(r_ia1) * (IW+18)'(-SQRT3_HALF_Q16);

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_x2  <= CW'(alpha_c) <<< 15;
            r_y2  <= CW'(beta_c);
            r_pa2 <= r_pa1;
            for (int k = 0; k < 3; k++) begin
                if (r_d1[k] < 0) begin
                    r_dc2[k] <= '0;
                end else if (r_d1[k] > $signed(DDW'(r_limit))) begin
                    r_dc2[k] <= r_limit;
                end else begin
                    r_dc2[k] <= r_d1[k][14:0];
                end
            end
            r_q2 <= r_q1;
            r_z2 <= r_z1;
        end
    end

    // ---------------- stage 3: quarter-turn pre-rotation, compare products
    logic signed [CW-1:0] r_x3, r_y3;
    logic signed [ZW-1:0] r_z3;
    logic signed [15:0]   r_pa3;
    logic [14:0]          r_dc3 [3];
    logic signed [33:0]   r_ms3 [3];
    logic [32:0]          r_mc3 [3];

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            case (r_q2)
                2'd1: begin
                    r_x3 <= -r_y2;
                    r_y3 <= r_x2;
                end
                2'd2: begin
                    r_x3 <= -r_x2;
                    r_y3 <= -r_y2;
                end
                2'd3: begin
                    r_x3 <= r_y2;
                    r_y3 <= -r_x2;
                end
                default: begin
                    r_x3 <= r_x2;
                    r_y3 <= r_y2;
                end
            endcase
            r_z3  <= r_z2;
            r_pa3 <= r_pa2;
            for (int k = 0; k < 3; k++) begin
                r_dc3[k] <= r_dc2[k];
                r_ms3[k] <= $signed({18'd0, r_period})
                          * (34'(HALF_DUTY) - $signed({19'd0, r_dc2[k]}));
                r_mc3[k] <= 33'(r_period) * (33'(HALF_DUTY) + 33'(r_dc2[k]));
            end
        end
    end

    // ---------------- CORDIC stages
    logic signed [CW-1:0] cx, cy;

    fcts_cordic #(.CW(CW)) u_cordic (
        .i_clk (i_clk),
        .i_en  (en[S_G1-1:S_CORD]),
        .i_x   (r_x3),
        .i_y   (r_y3),
        .i_z   (r_z3),
        .o_x   (cx),
        .o_y   (cy)
    );

    // ---------------- side results: compare rounding then delay line
    t_side               r_sd [S_CORD:NSTG-1];
    t_side               sd_c;
    logic signed [34:0]  set_r [3];
    logic [33:0]         clr_r [3];

    always_comb begin
        sd_c.pa = r_pa3;
        for (int k = 0; k < 3; k++) begin
            sd_c.duty[k] = r_dc3[k];
            set_r[k]     = (35'(r_ms3[k]) + 35'(16384)) >>> 15;
            clr_r[k]     = (34'(r_mc3[k]) + 34'(16384)) >> 15;
            if (set_r[k] < 0) begin
                sd_c.cset[k] = '0;
            end else if (set_r[k] > 35'(65535)) begin
                sd_c.cset[k] = 16'hffff;
            end else begin
                sd_c.cset[k] = set_r[k][15:0];
            end
            sd_c.cclr[k] = (clr_r[k] > 34'(65535)) ? 16'hffff : clr_r[k][15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = S_CORD; s < NSTG; s++) begin
            if (en[s]) begin
                r_sd[s] <= (s == S_CORD) ? sd_c : r_sd[(s == S_CORD) ? S_CORD : s - 1];
            end
        end
    end

    // ---------------- gain removal: partial products, sum and round, saturate
    localparam logic signed [HW-1:0] KG_H = HW'(CORDIC_INV_GAIN_Q16);
    localparam logic [15:0]          KG_L = 16'(CORDIC_INV_GAIN_Q16);

    logic signed [HW-1:0] r_phx, r_phy;
    logic [31:0]          r_plx, r_ply;
    logic signed [RW-1:0] r_rx, r_ry;
    logic signed [15:0]   r_ox, r_oy;

    always_ff @(posedge i_clk) begin
        if (en[S_G1]) begin
            r_phx <= HW'($signed(cx[CW-1:16])) * KG_H;
            r_phy <= HW'($signed(cy[CW-1:16])) * KG_H;
            r_plx <= cx[15:0] * KG_L;
            r_ply <= cy[15:0] * KG_L;
        end
        if (en[S_G1+1]) begin
            r_rx <= RW'(((SW'(r_phx) <<< 16) + $signed(SW'(r_plx)) + SW'(64'sh80000000))
                        >>> 32);
            r_ry <= RW'(((SW'(r_phy) <<< 16) + $signed(SW'(r_ply)) + SW'(64'sh80000000))
                        >>> 32);
        end
        if (en[S_G1+2]) begin
            if (r_rx > RW'(32767)) begin
                r_ox <= 16'sh7fff;
            end else if (r_rx < RW'(-32768)) begin
                r_ox <= -16'sh8000;
            end else begin
                r_ox <= r_rx[15:0];
            end
            if (r_ry > RW'(32767)) begin
                r_oy <= 16'sh7fff;
            end else if (r_ry < RW'(-32768)) begin
                r_oy <= -16'sh8000;
            end else begin
                r_oy <= r_ry[15:0];
            end
        end
    end

    // ---------------- output beat
    assign o_out.valid           = r_vld[NSTG-1];
    assign o_out.phase_a_current = r_sd[NSTG-1].pa;
    assign o_out.id_current      = r_ox;
    assign o_out.iq_current      = r_oy;
    assign o_out.duty_a          = r_sd[NSTG-1].duty[0];
    assign o_out.duty_b          = r_sd[NSTG-1].duty[1];
    assign o_out.duty_c          = r_sd[NSTG-1].duty[2];
    assign o_out.cmp_a_set       = r_sd[NSTG-1].cset[0];
    assign o_out.cmp_a_clear     = r_sd[NSTG-1].cclr[0];
    assign o_out.cmp_b_set       = r_sd[NSTG-1].cset[1];
    assign o_out.cmp_b_clear     = r_sd[NSTG-1].cclr[1];
    assign o_out.cmp_c_set       = r_sd[NSTG-1].cset[2];
    assign o_out.cmp_c_clear     = r_sd[NSTG-1].cclr[2];

endmodule

`default_nettype wire

// ===== rtl/core/fcts_checker.sv =====
// Port-level checker for the FOC transform top level, with its bind statement.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module fcts_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [14:0] i_duty_a,
    input wire logic [14:0] i_duty_b,
    input wire logic [14:0] i_duty_c,
    input wire logic [15:0] i_cmp_a_set,
    input wire logic [15:0] i_cmp_a_clear,
    input wire logic [15:0] i_cmp_b_set,
    input wire logic [15:0] i_cmp_b_clear
);

    // a stalled result beat stays offered
    `FCTS_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "out beat dropped under stall")

    // reset empties the pipeline
    `FCTS_ASSERT_NR(a_rst_empty, i_clk, !i_rst_n |=> !i_out_valid, "out valid after reset")

    // one phase is always parked at zero duty
    `FCTS_ASSERT(a_zero_phase, i_clk, i_rst_n, i_out_valid |-> (i_duty_a == 15'd0) || (i_duty_b == 15'd0) || (i_duty_c == 15'd0), "no phase at zero duty")

    // set edge never follows clear edge on phases A and B
    `FCTS_ASSERT(a_cmp_order, i_clk, i_rst_n, i_out_valid |-> (i_cmp_a_set <= i_cmp_a_clear) && (i_cmp_b_set <= i_cmp_b_clear), "compare pair out of order")

endmodule

bind foc_current_transform_svpwm_top fcts_checker u_fcts_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_duty_a      (o_out.duty_a),
    .i_duty_b      (o_out.duty_b),
    .i_duty_c      (o_out.duty_c),
    .i_cmp_a_set   (o_out.cmp_a_set),
    .i_cmp_a_clear (o_out.cmp_a_clear),
    .i_cmp_b_set   (o_out.cmp_b_set),
    .i_cmp_b_clear (o_out.cmp_b_clear)
);

`default_nettype wire
